// File: src/pcsd_pkg.sv
// Shared types and constants for the prefix code stream decoder.
package pcsd_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
    localparam int CODE_W       = MAX_CODE_LEN;
    localparam int ENT_W        = LEN_W + CODE_W;
    localparam int SYM_W        = 8;
    localparam int TAB_DEPTH    = 256;

    typedef enum logic [2:0] {
        PH_COUNT_LO = 3'd0,
        PH_COUNT_HI = 3'd1,
        PH_ENT_SYM  = 3'd2,
        PH_ENT_LEN  = 3'd3,
        PH_ENT_CODE = 3'd4,
        PH_BITCOUNT = 3'd5,
        PH_PAYLOAD  = 3'd6
    } phase_t;

    typedef struct packed {
        logic accept;
        logic bit_go;
        logic scan_go;
        logic emit;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic payload;
        logic acc_full;
        logic match;
        logic scan_end;
        logic last_bit;
        logic more_bits;
        logic pend_valid;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             err;
        logic             done;
    } result_t;

endpackage

// File: src/pcsd_ctrl.sv
// Sequencer for header bytes, payload bits, table scans and result hand-off.
module pcsd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pcsd_pkg::status_t st,
    output pcsd_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   can_move;

    assign s_tready = (state_reg == S_IDLE);
    assign can_move = !st.pend_valid || st.out_free;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.accept  = s_tready && s_tvalid;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.accept && st.payload) begin
                    state_next = S_BIT;
                end
            end
            S_BIT: begin
                cmd.bit_go = 1'b1;
                state_next = st.acc_full ? S_EMIT : S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_go = 1'b1;
                if (st.match || (st.scan_end && st.last_bit)) begin
                    state_next = S_EMIT;
                end else if (st.scan_end) begin
                    state_next = st.more_bits ? S_BIT : S_FLUSH;
                end
            end
            S_EMIT: begin
                if (can_move) begin
                    cmd.emit   = 1'b1;
                    state_next = st.more_bits ? S_BIT : S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (can_move) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/pcsd_datapath.sv
// Header parser, code table, bit accumulator, table scan and result registers.
module pcsd_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [7:0]                   s_tdata,
    input  pcsd_pkg::cmd_t               cmd,
    output pcsd_pkg::status_t            st,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [7:0]                   m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);

    pcsd_pkg::phase_t phase_reg;
    logic [15:0]      entries_reg;
    logic [7:0]       ent_sym_reg;
    logic [7:0]       ent_len_reg;
    logic [7:0]       ent_read_reg;
    logic [pcsd_pkg::CODE_W-1:0] ent_code_reg;
    logic [1:0]       hdr_idx_reg;
    logic [31:0]      bits_rem_reg;

    logic [pcsd_pkg::ENT_W-1:0] mem [pcsd_pkg::TAB_DEPTH];
    logic [pcsd_pkg::TAB_DEPTH-1:0] valid_reg;

    logic [pcsd_pkg::CODE_W-1:0] acc_code_reg;
    logic [pcsd_pkg::LEN_W-1:0]  acc_len_reg;
    logic [7:0]       byte_reg;
    logic [2:0]       bcnt_reg;
    logic             last_reg;

    logic [7:0]       scan_addr_reg;
    logic [7:0]       cmp_sym_reg;
    logic             cmp_live_reg;
    logic [pcsd_pkg::ENT_W-1:0] rd_reg;

    pcsd_pkg::result_t new_res_reg;
    pcsd_pkg::result_t pend_reg;
    logic              pend_valid_reg;
    pcsd_pkg::result_t out_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    // Code byte assembly: take up to eight bits, MSB first.
    logic [7:0] rem_bits;
    logic [3:0] take;
    logic [7:0] read_next;
    logic [pcsd_pkg::CODE_W+7:0] code_wide;
    logic [pcsd_pkg::CODE_W-1:0] code_next;
    logic usable;
    logic store;
    logic last_now;
    logic entry_hit;

    always_comb begin
        rem_bits  = ent_len_reg - ent_read_reg;
        take      = (rem_bits > 8'd8) ? 4'd8 : rem_bits[3:0];
        read_next = ent_read_reg + {4'd0, take};
        code_wide = ({8'd0, ent_code_reg} << take)
                  | {{pcsd_pkg::CODE_W{1'b0}}, (s_tdata >> (4'd8 - take))};
        code_next = code_wide[pcsd_pkg::CODE_W-1:0];
    end

    assign last_now  = (bits_rem_reg == 32'd1);
    assign entry_hit = cmp_live_reg && valid_reg[cmp_sym_reg]
                    && (rd_reg[pcsd_pkg::ENT_W-1:pcsd_pkg::CODE_W] == acc_len_reg)
                    && (rd_reg[pcsd_pkg::CODE_W-1:0] == acc_code_reg);

    always_comb begin
        st            = '0;
        st.payload    = (phase_reg == pcsd_pkg::PH_PAYLOAD);
        st.acc_full   = (acc_len_reg >= pcsd_pkg::LEN_W'(pcsd_pkg::MAX_CODE_LEN));
        st.match      = entry_hit;
        st.scan_end   = cmp_live_reg && (cmp_sym_reg == 8'hFF);
        st.last_bit   = last_reg;
        st.more_bits  = !last_reg && (bcnt_reg != 3'd0);
        st.pend_valid = pend_valid_reg;
        st.out_free   = !out_valid_reg || m_tready;
    end

    // Header parsing, one byte per accepted request.
    always_comb begin
        store  = 1'b0;
        usable = 1'b0;
        if (cmd.accept) begin
            unique case (phase_reg)
                pcsd_pkg::PH_ENT_LEN:  store = (s_tdata == 8'd0);
                pcsd_pkg::PH_ENT_CODE: store = (read_next >= ent_len_reg);
                default:               store = 1'b0;
            endcase
        end
        usable = (ent_len_reg != 8'd0)
              && (ent_len_reg <= 8'(pcsd_pkg::MAX_CODE_LEN))
              && (phase_reg == pcsd_pkg::PH_ENT_CODE);
    end

    always_ff @(posedge aclk) begin
        if (store && usable) begin
            mem[ent_sym_reg] <= {ent_len_reg[pcsd_pkg::LEN_W-1:0], code_next};
        end
        if (cmd.scan_go) begin
            rd_reg <= mem[scan_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= pcsd_pkg::PH_COUNT_LO;
            entries_reg    <= '0;
            ent_sym_reg    <= '0;
            ent_len_reg    <= '0;
            ent_read_reg   <= '0;
            ent_code_reg   <= '0;
            hdr_idx_reg    <= '0;
            bits_rem_reg   <= '0;
            valid_reg      <= '0;
            acc_code_reg   <= '0;
            acc_len_reg    <= '0;
            bcnt_reg       <= '0;
            last_reg       <= 1'b0;
            scan_addr_reg  <= '0;
            cmp_sym_reg    <= '0;
            cmp_live_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (store) begin
                valid_reg[ent_sym_reg] <= usable;
                entries_reg <= entries_reg - 16'd1;
                if (entries_reg == 16'd1) begin
                    phase_reg    <= pcsd_pkg::PH_BITCOUNT;
                    hdr_idx_reg  <= '0;
                    bits_rem_reg <= '0;
                end else begin
                    phase_reg <= pcsd_pkg::PH_ENT_SYM;
                end
            end
            if (cmd.accept) begin
                byte_reg <= s_tdata;
                bcnt_reg <= '0;
                unique case (phase_reg)
                    pcsd_pkg::PH_COUNT_LO: begin
                        valid_reg   <= '0;
                        entries_reg <= {8'd0, s_tdata};
                        phase_reg   <= pcsd_pkg::PH_COUNT_HI;
                    end
                    pcsd_pkg::PH_COUNT_HI: begin
                        entries_reg <= {s_tdata, entries_reg[7:0]};
                        if ({s_tdata, entries_reg[7:0]} == 16'd0) begin
                            phase_reg    <= pcsd_pkg::PH_BITCOUNT;
                            hdr_idx_reg  <= '0;
                            bits_rem_reg <= '0;
                        end else begin
                            phase_reg <= pcsd_pkg::PH_ENT_SYM;
                        end
                    end
                    pcsd_pkg::PH_ENT_SYM: begin
                        ent_sym_reg <= s_tdata;
                        phase_reg   <= pcsd_pkg::PH_ENT_LEN;
                    end
                    pcsd_pkg::PH_ENT_LEN: begin
                        ent_len_reg  <= s_tdata;
                        ent_read_reg <= '0;
                        ent_code_reg <= '0;
                        if (s_tdata != 8'd0) begin
                            phase_reg <= pcsd_pkg::PH_ENT_CODE;
                        end
                    end
                    pcsd_pkg::PH_ENT_CODE: begin
                        ent_read_reg <= read_next;
                        ent_code_reg <= code_next;
                    end
                    pcsd_pkg::PH_BITCOUNT: begin
                        case (hdr_idx_reg)
                            2'd0: bits_rem_reg[7:0]   <= s_tdata;
                            2'd1: bits_rem_reg[15:8]  <= s_tdata;
                            2'd2: bits_rem_reg[23:16] <= s_tdata;
                            default: bits_rem_reg[31:24] <= s_tdata;
                        endcase
                        hdr_idx_reg <= hdr_idx_reg + 2'd1;
                        if (hdr_idx_reg == 2'd3) begin
                            acc_code_reg <= '0;
                            acc_len_reg  <= '0;
                            phase_reg    <= ({s_tdata, bits_rem_reg[23:0]} == 32'd0)
                                          ? pcsd_pkg::PH_COUNT_LO : pcsd_pkg::PH_PAYLOAD;
                        end
                    end
                    pcsd_pkg::PH_PAYLOAD: begin
                    end
                    default: phase_reg <= pcsd_pkg::PH_COUNT_LO;
                endcase
            end
            if (cmd.bit_go) begin
                bits_rem_reg  <= bits_rem_reg - 32'd1;
                last_reg      <= last_now;
                byte_reg      <= {byte_reg[6:0], 1'b0};
                bcnt_reg      <= bcnt_reg + 3'd1;
                scan_addr_reg <= '0;
                cmp_live_reg  <= 1'b0;
                if (st.acc_full) begin
                    // The incoming bit is dropped together with the full accumulator.
                    new_res_reg  <= '{sym: '0, err: 1'b1, done: last_now};
                    acc_code_reg <= '0;
                    acc_len_reg  <= '0;
                end else begin
                    acc_code_reg <= {acc_code_reg[pcsd_pkg::CODE_W-2:0], byte_reg[7]};
                    acc_len_reg  <= acc_len_reg + pcsd_pkg::LEN_W'(1);
                end
            end
            if (cmd.scan_go) begin
                cmp_sym_reg   <= scan_addr_reg;
                cmp_live_reg  <= 1'b1;
                scan_addr_reg <= scan_addr_reg + 8'd1;
                // The scan runs from symbol zero up, so the lowest symbol wins.
                if (entry_hit) begin
                    new_res_reg  <= '{sym: cmp_sym_reg, err: 1'b0, done: last_reg};
                    acc_code_reg <= '0;
                    acc_len_reg  <= '0;
                end else if (st.scan_end && last_reg) begin
                    new_res_reg  <= '{sym: '0, err: 1'b1, done: 1'b1};
                    acc_code_reg <= '0;
                    acc_len_reg  <= '0;
                end
            end
            // A result stays in the pending slot until the next one, or the end
            // of the byte, tells whether it closes the run.
            if (cmd.emit) begin
                if (pend_valid_reg) begin
                    out_reg       <= pend_reg;
                    out_last_reg  <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                pend_reg       <= new_res_reg;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.flush) begin
                if (pend_valid_reg) begin
                    out_reg       <= pend_reg;
                    out_last_reg  <= 1'b1;
                    out_valid_reg <= 1'b1;
                end
                pend_valid_reg <= 1'b0;
                if (bits_rem_reg == 32'd0) begin
                    acc_code_reg <= '0;
                    acc_len_reg  <= '0;
                    phase_reg    <= pcsd_pkg::PH_COUNT_LO;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.sym;
    assign m_tuser  = {out_reg.done, out_reg.err};
    assign m_tlast  = out_last_reg;

    a_err_no_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.err) |-> (out_reg.sym == '0))
        else $error("error result carries a nonzero symbol");

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_len_reg <= pcsd_pkg::LEN_W'(pcsd_pkg::MAX_CODE_LEN))
        else $error("accumulator longer than the maximum code length");

    a_end_of_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush && bits_rem_reg == 32'd0) |=> (phase_reg == pcsd_pkg::PH_COUNT_LO))
        else $error("stream end did not return to header parsing");

    a_done_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && new_res_reg.done) |-> !st.more_bits)
        else $error("bits processed after the final payload bit");

endmodule

// File: src/prefix_code_stream_decoder.sv
// Top level of the prefix code stream decoder.
//
// The s_ channel takes the container one byte per request: a 16-bit entry
// count, the code table entries, a 32-bit payload bit count and the payload.
// Header bytes are taken back to back. A payload byte is worked one bit at
// a time: each bit enters the accumulator and the 256-entry code table
// memory is swept through its single read port, ending early when an entry
// matches; a bit that meets a full accumulator yields an error without a
// sweep. A payload byte is fully worked before the next byte is taken.
// Each decoded symbol or error event leaves on the m_ channel; m_tlast marks
// the last result caused by a byte. A result waits in a pending slot until
// the next result or the end of the byte, then enters the output register.
// When the receiver stalls, the decoder holds at the next result hand-off and
// stops taking bytes; header bytes are still taken while a result waits.
// Reset returns parsing to the entry count, marks every table entry invalid
// at once and empties the result registers.
module prefix_code_stream_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] symbol
    output logic [1:0] m_tuser,   // [0] code_error, [1] stream_done
    output logic       m_tlast
);

    pcsd_pkg::cmd_t    cmd;
    pcsd_pkg::status_t st;

    pcsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pcsd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/sv/prefix_code_stream_decoder_checker.sv
// Checker for the prefix code stream decoder: predicts decoded symbols and compares.
`timescale 1ns / 100ps
module prefix_code_stream_decoder_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending_count
);

    typedef struct packed {
        logic [7:0] sym;
        logic       err;
        logic       done;
        logic       last;
    } dec_result_t;

    dec_result_t symbol_queue[$];

    pcsd_pkg::phase_t phase;
    logic [15:0] entries_left;
    logic [7:0]  ent_sym;
    logic [7:0]  ent_len;
    logic [7:0]  ent_bits;
    logic [63:0] ent_code;
    logic [1:0]  cnt_idx;
    logic [31:0] bits_left;
    logic        tab_ok[256];
    logic [7:0]  tab_len[256];
    logic [63:0] tab_code[256];
    logic [63:0] acc_code;
    logic [7:0]  acc_len;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void clear_codes();
        for (int i = 0; i < 256; i++) begin
            tab_ok[i] = 0;
            tab_len[i] = 0;
            tab_code[i] = 0;
        end
    endfunction

    function automatic void enter_bitcount();
        phase = pcsd_pkg::PH_BITCOUNT;
        cnt_idx = 0;
        bits_left = 0;
    endfunction

    function automatic void commit_entry();
        logic ok;
        ok = ent_len > 0 && ent_len <= pcsd_pkg::MAX_CODE_LEN;
        tab_ok[ent_sym] = ok;
        tab_len[ent_sym] = ok ? ent_len : 8'd0;
        tab_code[ent_sym] = ok ? ent_code : 64'd0;
        entries_left = entries_left - 16'd1;
        if (entries_left == 0) enter_bitcount();
        else phase = pcsd_pkg::PH_ENT_SYM;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        dec_result_t res[$];
        dec_result_t r;
        int take;
        int hit;
        logic fin;
        case (phase)
            pcsd_pkg::PH_COUNT_LO: begin
                clear_codes();
                entries_left = {8'd0, b};
                phase = pcsd_pkg::PH_COUNT_HI;
            end
            pcsd_pkg::PH_COUNT_HI: begin
                entries_left = {b, entries_left[7:0]};
                if (entries_left == 0) enter_bitcount();
                else phase = pcsd_pkg::PH_ENT_SYM;
            end
            pcsd_pkg::PH_ENT_SYM: begin
                ent_sym = b;
                phase = pcsd_pkg::PH_ENT_LEN;
            end
            pcsd_pkg::PH_ENT_LEN: begin
                ent_len = b;
                ent_bits = 0;
                ent_code = 0;
                if (b == 0) commit_entry();
                else phase = pcsd_pkg::PH_ENT_CODE;
            end
            pcsd_pkg::PH_ENT_CODE: begin
                take = ent_len - ent_bits;
                if (take > 8) take = 8;
                for (int j = 0; j < take; j++) ent_code = {ent_code[62:0], b[7-j]};
                ent_bits = ent_bits + 8'(take);
                if (ent_bits >= ent_len) commit_entry();
            end
            pcsd_pkg::PH_BITCOUNT: begin
                bits_left = bits_left | ({24'd0, b} << (8 * cnt_idx));
                if (cnt_idx == 3) begin
                    cnt_idx = 0;
                    acc_code = 0;
                    acc_len = 0;
                    phase = (bits_left == 0) ? pcsd_pkg::PH_COUNT_LO : pcsd_pkg::PH_PAYLOAD;
                end else begin
                    cnt_idx++;
                end
            end
            pcsd_pkg::PH_PAYLOAD: begin
                take = (bits_left >= 32'd8) ? 8 : int'(bits_left);
                for (int j = 0; j < take; j++) begin
                    bits_left--;
                    fin = bits_left == 0;
                    r = '0;
                    if (acc_len >= pcsd_pkg::MAX_CODE_LEN) begin
                        r.err = 1;
                        r.done = fin;
                        res.insert(res.size(), r);
                        acc_code = 0;
                        acc_len = 0;
                    end else begin
                        acc_code = {acc_code[62:0], b[7-j]};
                        acc_len++;
                        hit = -1;
                        for (int s = 0; s < 256; s++)
                            if (hit < 0 && tab_ok[s] && tab_len[s] == acc_len
                                && tab_code[s] == acc_code) hit = s;
                        if (hit >= 0 || fin) begin
                            r.sym = hit >= 0 ? hit[7:0] : 8'd0;
                            r.err = hit < 0;
                            r.done = fin;
                            res.insert(res.size(), r);
                            acc_code = 0;
                            acc_len = 0;
                        end
                    end
                end
                if (bits_left == 0) begin
                    acc_code = 0;
                    acc_len = 0;
                    phase = pcsd_pkg::PH_COUNT_LO;
                end
            end
            default: phase = pcsd_pkg::PH_COUNT_LO;
        endcase
        if (res.size() > 0) res[res.size()-1].last = 1;
        foreach (res[i]) symbol_queue.insert(symbol_queue.size(), res[i]);
    endfunction

    initial begin
        fail_count = 0;
        pending_count = 0;
        phase = pcsd_pkg::PH_COUNT_LO;
        entries_left = 0;
        ent_sym = 0;
        ent_len = 0;
        ent_bits = 0;
        ent_code = 0;
        cnt_idx = 0;
        bits_left = 0;
        acc_code = 0;
        acc_len = 0;
        clear_codes();
    end

    always @(posedge aclk) begin
        dec_result_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (symbol_queue.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = symbol_queue.pop_front();
                    if (m_tdata !== e.sym || m_tuser[0] !== e.err
                        || m_tuser[1] !== e.done || m_tlast !== e.last)
                        report_mismatch($sformatf(
                            "got sym %0h err %b done %b last %b, want %0h %b %b %b",
                            m_tdata, m_tuser[0], m_tuser[1], m_tlast,
                            e.sym, e.err, e.done, e.last));
                end
            end
            if (s_tvalid && s_tready) decode_byte(s_tdata);
            pending_count = symbol_queue.size();
        end
    end

endmodule

// File: tb/sv/prefix_code_stream_decoder_test.sv
// Top of the prefix code stream decoder testbench: stimulus and verdict.
`timescale 1ns / 100ps
module prefix_code_stream_decoder_test;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;
    int         fail_count;
    int         pending_count;
    logic [7:0] stream_bytes[$];

    prefix_code_stream_decoder dut (.*);
    prefix_code_stream_decoder_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    task automatic add_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endtask

    // Byte-level pieces of a container.
    task automatic put_count(input int n);
        add_byte(n[7:0]);
        add_byte(n[15:8]);
    endtask

    task automatic put_entry(input int sym, input int len, input logic [63:0] code);
        logic [63:0] msb;
        add_byte(sym[7:0]);
        add_byte(len[7:0]);
        // Code bits go out MSB first, left-aligned in whole bytes.
        msb = (len > 0 && len <= 64) ? code << (64 - len) : 64'd0;
        for (int k = 0; k < (len + 7) / 8; k++) begin
            if (k < 8) add_byte(msb[63-8*k -: 8]);
            else add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic put_bitcount(input logic [31:0] n);
        for (int k = 0; k < 4; k++) add_byte(n[8*k +: 8]);
    endtask

    // A random well-formed container with a small table and a short payload.
    task automatic build_container();
        int n;
        int len;
        int nb;
        n = $urandom_range(0, 6);
        put_count(n);
        for (int i = 0; i < n; i++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 4);
            put_entry($urandom_range(0, 255), len,
                      {$urandom(), $urandom()} & ((64'd1 << len) - 1));
        end
        nb = $urandom_range(0, 40);
        put_bitcount(nb);
        for (int i = 0; i < (nb + 7) / 8; i++) add_byte(8'($urandom_range(0, 255)));
    endtask

    // The receiver waits a drawn number of cycles before taking each result.
    initial begin
        int stall;
        m_tready = 0;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            repeat (stall) @(negedge aclk);
            m_tready = 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
            m_tready = 0;
        end
    end

    initial begin
        int gap;
        s_tvalid = 0;
        s_tdata = 0;
        aresetn = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: duplicate symbol, zero and overlong entries.
        put_count(16'd5);
        put_entry(8'hFF, 2, 64'b10);
        put_entry(8'hFF, 1, 64'b1);
        put_entry(8'h00, 0, 0);
        put_entry(8'h10, 33, 0);
        put_entry(8'h05, 2, 64'b01);
        put_bitcount(32'd11);
        add_byte(8'b1010_0110);
        add_byte(8'b1001_1111);
        // Zero entries, zero bits; then empty table so the accumulator overflows.
        put_count(0);
        put_bitcount(0);
        put_count(0);
        put_bitcount(32'd40);
        repeat (5) add_byte(8'h00);
        // Full-length codes and equal codes under two symbols.
        put_count(3);
        put_entry(8'h07, 32, 64'hFFFF_FFFF);
        put_entry(8'h03, 1, 64'b0);
        put_entry(8'h01, 1, 64'b0);
        put_bitcount(32'd40);
        repeat (4) add_byte(8'hFF);
        add_byte(8'h55);

        while (stream_bytes.size() < 280) build_container();
        // A little noise before a final clean container.
        repeat (5) add_byte(8'($urandom_range(0, 255)));
        put_count(0);
        put_bitcount(0);

        while (stream_bytes.size() > 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            repeat (gap) @(negedge aclk);
            s_tvalid = 1;
            s_tdata = stream_bytes.pop_front();
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            @(negedge aclk);
            s_tvalid = 0;
        end
        while (pending_count > 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
